FILE: rtl/core/mbrx_pkg.sv
// Package for the Modbus RTU response receiver.
// Holds status and mode codes, CRC constants, the control state type and the CRC command struct.
// No dependencies.
package mbrx_pkg;

    localparam logic [2:0] STAT_READ_OK   = 3'd0;
    localparam logic [2:0] STAT_READ_EXC  = 3'd1;
    localparam logic [2:0] STAT_CRC_ERR   = 3'd2;
    localparam logic [2:0] STAT_TOO_LONG  = 3'd3;
    localparam logic [2:0] STAT_WRITE_ACK = 3'd4;
    localparam logic [2:0] STAT_WRITE_EXC = 3'd5;

    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic CFG_STATION = 1'b0;
    localparam logic CFG_MODE    = 1'b1;

    localparam logic [7:0] STATION_RESET = 8'h01;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [8:0] FRAME_OVERHEAD = 9'd5;
    localparam logic [8:0] EXC_FRAME_LEN  = 9'd5;
    localparam logic [8:0] WRITE_FRAME_LEN = 9'd8;
    localparam int         DATA_OFFSET    = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CRC_WAIT,
        S_RD_LO,
        S_RD_HI,
        S_EMIT,
        S_RUN_RD,
        S_RUN_EMIT
    } rx_state_t;

    typedef struct packed {
        logic       init;
        logic       start;
        logic [7:0] data;
    } crc_cmd_t;

endpackage

FILE: rtl/core/mbrx_crc_serial.sv
// Bit-serial CRC-16/MODBUS engine: one shift of the reflected polynomial per cycle while busy and no command arrives.
// Takes a byte per start command and shifts it through all eight bits before busy drops.
// Depends on mbrx_pkg.
module mbrx_crc_serial (
    input  logic               clk,
    input  logic               rst_n,
    input  mbrx_pkg::crc_cmd_t cmd,
    output logic               busy,
    output logic [15:0]        crc_value
);
    import mbrx_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic        busy_reg, busy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_INIT;
            bit_cnt_reg <= '0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            crc_reg     <= crc_next;
            bit_cnt_reg <= bit_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    always_comb
    begin
        crc_next     = crc_reg;
        bit_cnt_next = bit_cnt_reg;
        busy_next    = busy_reg;
        priority if (cmd.start)
        begin
            crc_next     = (cmd.init ? CRC_INIT : crc_reg) ^ {8'h00, cmd.data};
            bit_cnt_next = '0;
            busy_next    = 1'b1;
        end
        else if (cmd.init)
        begin
            crc_next = CRC_INIT;
        end
        else if (busy_reg)
        begin
            crc_next     = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
            bit_cnt_next = bit_cnt_reg + 3'd1;
            if (bit_cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
        else
        begin
            crc_next = crc_reg;
        end
    end

    assign busy      = busy_reg;
    assign crc_value = crc_reg;

endmodule

FILE: rtl/core/mbrx_frame_buf.sv
// Frame byte store: one write port, one read port with registered read data.
// No reset; entries are only read after being written in the current frame.
// No dependencies.
module mbrx_frame_buf #(
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/modbus_rtu_response_receiver.sv
// Modbus RTU response receiver: frame control, config registers and result register.
// Instantiates mbrx_crc_serial and mbrx_frame_buf; depends on mbrx_pkg.
//
//   channel  dir  handshake               payload
//   rx       in   rx_valid / rx_stall     rx_byte
//   res      out  res_valid / res_stall   frame_status, data_valid, data_byte, last_result
//   cfg      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A byte dropped outside a frame stays in S_IDLE; a stored byte goes through S_EVAL and
// S_CRC_WAIT, which waits out the bit-serial CRC if the byte enters it. A closing byte reads
// the CRC bytes in S_EVAL and S_RD_LO and checks them in S_RD_HI; one result follows, or one
// per data byte on a read response (single buffer read port). A length failure goes to S_EMIT.
// Reset is immediate; the frame buffer needs no clearing pass.
// A stalled result holds its register; the block waits on it only when the next result is due.
module modbus_rtu_response_receiver #(
    parameter int BUF_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [2:0] frame_status,
    output logic       data_valid,
    output logic [7:0] data_byte,
    output logic       last_result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);
    import mbrx_pkg::*;

    localparam int         AW      = $clog2(BUF_DEPTH);
    localparam logic [8:0] DEPTH_W = 9'(BUF_DEPTH);

    rx_state_t     state_reg, state_next;
    logic [7:0]    station_reg;
    logic [1:0]    mode_reg;
    logic          frame_open_reg, frame_open_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [7:0]    byte_reg, byte_next;
    logic [7:0]    func_reg, func_next;
    logic [7:0]    count_reg, count_next;
    logic [7:0]    lo_reg, lo_next;
    logic [7:0]    rem_reg, rem_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [2:0]    pend_status_reg, pend_status_next;
    logic          pend_dv_reg, pend_dv_next;
    logic [7:0]    pend_data_reg, pend_data_next;

    logic          res_valid_reg;
    logic [2:0]    status_out_reg;
    logic          dv_out_reg;
    logic [7:0]    data_out_reg;
    logic          last_out_reg;

    logic          load_out;
    logic [2:0]    load_status;
    logic          load_dv;
    logic [7:0]    load_data;
    logic          load_last;

    crc_cmd_t      crc_cmd;
    logic          crc_busy;
    logic [15:0]   crc_value;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic          mode_ok;
    logic          exc;
    logic [8:0]    total;
    logic [8:0]    idx_w;
    logic          too_long;
    logic [AW-1:0] eff_idx;
    logic          slot_free;

    mbrx_crc_serial u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (crc_cmd),
        .busy      (crc_busy),
        .crc_value (crc_value)
    );

    mbrx_frame_buf #(
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rx_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !rx_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= STATION_RESET;
            mode_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STATION: station_reg <= cfg_data;
                CFG_MODE:    mode_reg    <= cfg_data[1:0];
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    assign mode_ok   = (mode_reg == MODE_READ) || (mode_reg == MODE_WRITE);
    assign exc       = func_reg[7];
    assign idx_w     = 9'(idx_reg);
    assign eff_idx   = frame_open_reg ? idx_reg : '0;
    assign slot_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        priority if (exc)
        begin
            total = EXC_FRAME_LEN;
        end
        else if (mode_reg == MODE_READ)
        begin
            total = {1'b0, count_reg} + FRAME_OVERHEAD;
        end
        else
        begin
            total = WRITE_FRAME_LEN;
        end
    end

    assign too_long = (mode_reg == MODE_READ) && !exc && (total > DEPTH_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            frame_open_reg <= 1'b0;
            idx_reg        <= '0;
            rem_reg        <= '0;
            ptr_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            frame_open_reg <= frame_open_next;
            idx_reg        <= idx_next;
            rem_reg        <= rem_next;
            ptr_reg        <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg        <= byte_next;
        func_reg        <= func_next;
        count_reg       <= count_next;
        lo_reg          <= lo_next;
        pend_status_reg <= pend_status_next;
        pend_dv_reg     <= pend_dv_next;
        pend_data_reg   <= pend_data_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        frame_open_next  = frame_open_reg;
        idx_next         = idx_reg;
        byte_next        = byte_reg;
        func_next        = func_reg;
        count_next       = count_reg;
        lo_next          = lo_reg;
        rem_next         = rem_reg;
        ptr_next         = ptr_reg;
        pend_status_next = pend_status_reg;
        pend_dv_next     = pend_dv_reg;
        pend_data_next   = pend_data_reg;
        crc_cmd          = '0;
        crc_cmd.data     = byte_reg;
        wr_en            = 1'b0;
        wr_addr          = eff_idx;
        rd_en            = 1'b0;
        rd_addr          = ptr_reg;
        load_out         = 1'b0;
        load_status      = pend_status_reg;
        load_dv          = pend_dv_reg;
        load_data        = pend_data_reg;
        load_last        = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (rx_valid)
                begin
                    priority if (!mode_ok)
                    begin
                        frame_open_next = 1'b0;
                        idx_next        = '0;
                        crc_cmd.init    = 1'b1;
                    end
                    else if (!frame_open_reg && (rx_byte != station_reg))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        crc_cmd.init    = !frame_open_reg;
                        frame_open_next = 1'b1;
                        wr_en           = 1'b1;
                        byte_next       = rx_byte;
                        idx_next        = eff_idx;
                        if (eff_idx == AW'(1))
                        begin
                            func_next = rx_byte;
                        end
                        if (eff_idx == AW'(2))
                        begin
                            count_next = rx_byte;
                        end
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                priority if (idx_reg < AW'(2))
                begin
                    crc_cmd.start = 1'b1;
                    idx_next      = idx_reg + AW'(1);
                    state_next    = S_CRC_WAIT;
                end
                else if (too_long)
                begin
                    pend_status_next = STAT_TOO_LONG;
                    pend_dv_next     = 1'b0;
                    pend_data_next   = '0;
                    frame_open_next  = 1'b0;
                    idx_next         = '0;
                    crc_cmd.init     = 1'b1;
                    state_next       = S_EMIT;
                end
                else if ((idx_w + 9'd1) < total)
                begin
                    crc_cmd.start = ((idx_w + 9'd2) < total);
                    idx_next      = idx_reg + AW'(1);
                    state_next    = S_CRC_WAIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(total - 9'd2);
                    state_next = S_RD_LO;
                end
            end
            S_CRC_WAIT:
            begin
                if (!crc_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD_LO:
            begin
                lo_next    = rd_data;
                rd_en      = 1'b1;
                rd_addr    = AW'(total - 9'd1);
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                frame_open_next = 1'b0;
                idx_next        = '0;
                crc_cmd.init    = 1'b1;
                pend_dv_next    = 1'b0;
                pend_data_next  = '0;
                state_next      = S_EMIT;
                priority if ({rd_data, lo_reg} != crc_value)
                begin
                    pend_status_next = STAT_CRC_ERR;
                end
                else if (exc)
                begin
                    pend_status_next = (mode_reg == MODE_READ) ? STAT_READ_EXC
                                                               : STAT_WRITE_EXC;
                    pend_dv_next     = 1'b1;
                    pend_data_next   = count_reg;
                end
                else if (mode_reg == MODE_WRITE)
                begin
                    pend_status_next = STAT_WRITE_ACK;
                end
                else if (count_reg == 8'd0)
                begin
                    pend_status_next = STAT_READ_OK;
                end
                else
                begin
                    ptr_next   = AW'(DATA_OFFSET);
                    rem_next   = count_reg;
                    state_next = S_RUN_RD;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RUN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg;
                state_next = S_RUN_EMIT;
            end
            S_RUN_EMIT:
            begin
                load_status = STAT_READ_OK;
                load_dv     = 1'b1;
                load_data   = rd_data;
                load_last   = (rem_reg == 8'd1);
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    rem_next   = rem_reg - 8'd1;
                    ptr_next   = ptr_reg + AW'(1);
                    state_next = (rem_reg == 8'd1) ? S_IDLE : S_RUN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register: one beat held until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_out_reg <= load_status;
            dv_out_reg     <= load_dv;
            data_out_reg   <= load_data;
            last_out_reg   <= load_last;
        end
    end

    assign res_valid    = res_valid_reg;
    assign frame_status = status_out_reg;
    assign data_valid   = dv_out_reg;
    assign data_byte    = data_out_reg;
    assign last_result  = last_out_reg;

    a_closed_frame_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_open_reg |-> (idx_reg == '0))
        else $error("closed frame with nonzero byte index");

    a_idle_crc_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !crc_busy)
        else $error("idle while CRC engine busy");

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN_EMIT) |-> (rem_reg != 8'd0))
        else $error("data run with nothing left");

    a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |->
            ($past(state_reg) == S_EMIT) || ($past(state_reg) == S_RUN_EMIT))
        else $error("result beat outside an emit state");

endmodule

FILE: tb/modbus_rtu_response_receiver_tb.sv
// Testbench for modbus_rtu_response_receiver: directed and random response frames with
// random idling on the byte and result channels, checked against a local predictor.
// Depends on mbrx_pkg and the receiver RTL.
`timescale 1ns / 1ps

module modbus_rtu_response_receiver_tb;

    import mbrx_pkg::*;

    localparam int          BUF_DEPTH     = 64;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          RANDOM_BYTES  = 40;
    localparam logic [1:0]  MODE_IDLE     = 2'd0;
    localparam logic [1:0]  MODE_SPARE    = 2'd3;

    typedef logic [7:0] byte_seq_t[$];

    typedef struct packed {
        logic [2:0] status;
        logic       valid;
        logic [7:0] value;
        logic       last;
    } rx_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [2:0] frame_status;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       last_result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = CFG_STATION;
    logic [7:0] cfg_data = 8'h00;

    // predictor state
    logic [7:0]  pred_station = STATION_RESET;
    logic [1:0]  pred_mode = MODE_IDLE;
    logic [7:0]  frame_bytes[BUF_DEPTH];
    int          frame_len = 0;
    bit          frame_active = 1'b0;
    logic [15:0] frame_crc = CRC_INIT;
    rx_result_t  pending_results[$];

    bit quiet_run = 1'b0;
    int error_count = 0;
    int results_seen = 0;
    int bytes_sent = 0;
    int active_bytes = 0;
    int frames_sent = 0;

    modbus_rtu_response_receiver #(
        .BUF_DEPTH(BUF_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .frame_status(frame_status),
        .data_valid  (data_valid),
        .data_byte   (data_byte),
        .last_result (last_result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] crc16_shift_in(input logic [15:0] crc,
                                                   input logic [7:0] value);
        logic [15:0] c;
        c = crc ^ {8'h00, value};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [15:0] frame_crc_of(input byte_seq_t body);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (body[i])
            crc = crc16_shift_in(crc, body[i]);
        return crc;
    endfunction

    function automatic void queue_result(input logic [2:0] status, input logic valid,
                                         input logic [7:0] value, input logic last);
        rx_result_t r;
        r = '{status, valid, value, last};
        pending_results.push_back(r);
    endfunction

    function automatic void drop_frame();
        frame_active = 1'b0;
        frame_len = 0;
        frame_crc = CRC_INIT;
    endfunction

    function automatic void predict_rx_byte(input logic [7:0] value);
        int idx;
        int total;
        int n;
        bit exc;
        logic [15:0] got_crc;
        if (pred_mode != MODE_READ && pred_mode != MODE_WRITE) begin
            drop_frame();
            return;
        end
        if (!frame_active) begin
            if (value != pred_station)
                return;
            frame_active = 1'b1;
            frame_len = 0;
            frame_crc = CRC_INIT;
        end
        idx = frame_len;
        frame_bytes[idx] = value;
        if (idx < 2) begin
            frame_crc = crc16_shift_in(frame_crc, value);
            frame_len = idx + 1;
            return;
        end
        exc = frame_bytes[1][7];
        if (exc)
            total = int'(EXC_FRAME_LEN);
        else if (pred_mode == MODE_READ)
            total = int'(frame_bytes[2]) + int'(FRAME_OVERHEAD);
        else
            total = int'(WRITE_FRAME_LEN);
        if (pred_mode == MODE_READ && !exc && total > BUF_DEPTH) begin
            queue_result(STAT_TOO_LONG, 1'b0, 8'h00, 1'b1);
            drop_frame();
            return;
        end
        if (idx < total - 2)
            frame_crc = crc16_shift_in(frame_crc, value);
        if (idx < total - 1) begin
            frame_len = idx + 1;
            return;
        end
        got_crc = {frame_bytes[total - 1], frame_bytes[total - 2]};
        if (got_crc != frame_crc)
            queue_result(STAT_CRC_ERR, 1'b0, 8'h00, 1'b1);
        else if (exc)
            queue_result(pred_mode == MODE_READ ? STAT_READ_EXC : STAT_WRITE_EXC, 1'b1,
                         frame_bytes[2], 1'b1);
        else if (pred_mode == MODE_WRITE)
            queue_result(STAT_WRITE_ACK, 1'b0, 8'h00, 1'b1);
        else if (frame_bytes[2] == 8'h00)
            queue_result(STAT_READ_OK, 1'b0, 8'h00, 1'b1);
        else begin
            n = frame_bytes[2];
            for (int i = 0; i < n; i++)
                queue_result(STAT_READ_OK, 1'b1, frame_bytes[DATA_OFFSET + i], i == n - 1);
        end
        drop_frame();
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // sample every beat on the rising edge
    always @(posedge clk) begin
        rx_result_t got;
        rx_result_t want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_STATION)
                    pred_station = cfg_data;
                else
                    pred_mode = cfg_data[1:0];
            end
            if (rx_valid && !rx_stall)
                predict_rx_byte(rx_byte);
            if (res_valid && !res_stall) begin
                got = '{frame_status, data_valid, data_byte, last_result};
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result status %0d valid %0b byte %02h last %0b",
                        got.status, got.valid, got.value, got.last));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "status %0d/%0d valid %0b/%0b byte %02h/%02h last %0b/%0b (got/exp)",
                            got.status, want.status, got.valid, want.valid,
                            got.value, want.value, got.last, want.last));
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= !quiet_run && ($urandom_range(99) < 17);
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (!quiet_run && $urandom_range(99) < 17) begin
            gap = $urandom_range(1, 8);
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= value;
        do @(posedge clk); while (rx_stall);
        bytes_sent++;
        if (pred_mode == MODE_READ || pred_mode == MODE_WRITE)
            active_bytes++;
    endtask

    task automatic wait_until_settled();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] station, input logic [1:0] mode);
        wait_until_settled();
        write_register(CFG_STATION, station);
        write_register(CFG_MODE, {6'b0, mode});
    endtask

    function automatic byte_seq_t read_body(input int n);
        byte_seq_t body;
        body = {pred_station, 8'($urandom_range(127)), 8'(n)};
        repeat (n) body.push_back(8'($urandom_range(255)));
        return body;
    endfunction

    function automatic byte_seq_t exc_body(input logic [7:0] code);
        byte_seq_t body;
        body = {pred_station, 8'h80 | 8'($urandom_range(127)), code};
        return body;
    endfunction

    function automatic byte_seq_t write_body();
        byte_seq_t body;
        body = {pred_station, 8'($urandom_range(127))};
        repeat (4) body.push_back(8'($urandom_range(255)));
        return body;
    endfunction

    task automatic send_frame(input byte_seq_t body, input bit corrupt);
        logic [15:0] crc;
        crc = frame_crc_of(body);
        if (corrupt)
            crc ^= 16'h0001 << $urandom_range(15);
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        foreach (body[i])
            send_byte(body[i]);
        frames_sent++;
    endtask

    task automatic send_long_header(input logic [7:0] n);
        send_byte(pred_station);
        send_byte(8'($urandom_range(127)));
        send_byte(n);
    endtask

    task automatic test_read_responses();
        byte_seq_t body;
        configure(8'h11, MODE_READ);
        send_frame(read_body(0), 1'b0);
        body = read_body(1);
        body[3] = 8'h00;
        send_frame(body, 1'b0);
        body = read_body(2);
        body[3] = 8'hFF;
        send_frame(body, 1'b0);
        send_frame(read_body(3), 1'b1);
    endtask

    task automatic test_exceptions();
        send_frame(exc_body(8'h02), 1'b0);
        configure(8'h11, MODE_WRITE);
        send_frame(write_body(), 1'b0);
        send_frame(exc_body(8'h04), 1'b0);
        send_frame(write_body(), 1'b1);
    endtask

    task automatic test_length_limit();
        configure(8'hA5, MODE_READ);
        // full-depth frame and its result run with no idling on either side
        quiet_run = 1'b1;
        send_frame(read_body(BUF_DEPTH - 5), 1'b0);
        wait_until_settled();
        quiet_run = 1'b0;
        send_long_header(8'(BUF_DEPTH - 4));
        send_long_header(8'hFF);
    endtask

    task automatic test_address_and_idle();
        configure(8'h00, MODE_READ);
        send_byte(8'h7E);
        send_byte(8'hFF);
        send_frame(read_body(2), 1'b0);
        configure(8'hFF, MODE_WRITE);
        send_frame(write_body(), 1'b0);
        configure(8'hFF, MODE_IDLE);
        send_frame(write_body(), 1'b0);
        configure(8'hFF, MODE_SPARE);
        send_frame(write_body(), 1'b0);
        // an idle-mode byte closes a frame left open
        configure(8'hFF, MODE_READ);
        send_byte(8'hFF);
        send_byte(8'h03);
        configure(8'hFF, MODE_IDLE);
        send_byte(8'h10);
        configure(8'hFF, MODE_READ);
        send_frame(read_body(1), 1'b0);
    endtask

    task automatic test_mode_switch_in_frame();
        byte_seq_t body;
        logic [15:0] crc;
        configure(8'h22, MODE_READ);
        body = read_body(10);
        body = body[0:5];
        crc = frame_crc_of(body);
        foreach (body[i])
            send_byte(body[i]);
        // now an 8-byte write echo: the next two beats are its CRC
        configure(8'h22, MODE_WRITE);
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        body = read_body(0);
        foreach (body[i])
            send_byte(body[i]);
        send_byte(8'h44);
        configure(8'h22, MODE_READ);
        send_byte(8'($urandom_range(255)));
    endtask

    task automatic test_random_traffic();
        byte_seq_t body;
        int frame_no;
        int pick;
        int first_byte;
        bit corrupt;
        logic [7:0] station;
        logic [1:0] mode;
        first_byte = bytes_sent;
        frame_no = 0;
        while (bytes_sent - first_byte < RANDOM_BYTES) begin
            if (frame_no % 3 == 0) begin
                pick = $urandom_range(99);
                mode = pick < 45 ? MODE_READ : pick < 90 ? MODE_WRITE :
                       pick < 95 ? MODE_IDLE : MODE_SPARE;
                station = $urandom_range(99) < 10 ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                                   : 8'($urandom_range(255));
                configure(station, mode);
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                corrupt = pick >= 60;
                if ($urandom_range(99) < 12)
                    body = exc_body(8'($urandom_range(255)));
                else if (pred_mode == MODE_WRITE)
                    body = write_body();
                else if ($urandom_range(99) < 90)
                    body = read_body($urandom_range(0, 8));
                else
                    body = read_body($urandom_range(9, BUF_DEPTH - 5));
                send_frame(body, corrupt);
            end else if (pick < 77) begin
                send_long_header(8'($urandom_range(BUF_DEPTH - 4, 255)));
            end else if (pick < 89) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
            end else if (pick < 95) begin
                body = read_body($urandom_range(1, 6));
                repeat ($urandom_range(1, body.size() - 1))
                    send_byte(body.pop_front());
            end else begin
                wait_until_settled();
            end
            frame_no++;
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_read_responses();
        test_exceptions();
        test_length_limit();
        test_address_and_idle();
        test_mode_switch_in_frame();
        test_random_traffic();
        wait_until_settled();
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        $display("Run covered %0d bytes (%0d in active modes), %0d frames, %0d results",
                 bytes_sent, active_bytes, frames_sent, results_seen);
        $display("Read, write, exception, CRC error, length limit, idle and mode switch cases");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout at %0t", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mbrx_pkg.sv
rtl/core/mbrx_crc_serial.sv
rtl/core/mbrx_frame_buf.sv
rtl/core/modbus_rtu_response_receiver.sv
tb/modbus_rtu_response_receiver_tb.sv
